// File: sv/mbrc_pkg.sv
// Modbus RTU response checker: shared types, codes and the CRC-16 byte update.
// Used by every module of the checker; depends on nothing.
package mbrc_pkg;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 11;

  localparam logic [CFG_IDX_W-1:0] REG_RESPONSE_KIND = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_EXPECTED_BITS = 1'd1;

  localparam logic [1:0] KIND_BIT_READ = 2'd0;
  localparam logic [1:0] KIND_REG_READ = 2'd1;

  localparam logic [1:0] ITEM_REG_WORD  = 2'd0;
  localparam logic [1:0] ITEM_BIT_GROUP = 2'd1;
  localparam logic [1:0] ITEM_STATUS    = 2'd2;

  localparam logic [2:0] ST_OK          = 3'd0;
  localparam logic [2:0] ST_SHORT       = 3'd1;
  localparam logic [2:0] ST_CRC         = 3'd2;
  localparam logic [2:0] ST_EXCEPTION   = 3'd3;
  localparam logic [2:0] ST_DATA_SHORT  = 3'd4;
  localparam logic [2:0] ST_INCOMPLETE  = 3'd5;
  localparam logic [2:0] ST_WRITE_SHORT = 3'd6;

  localparam logic [15:0] CRC_SEED = 16'hFFFF;
  localparam logic [15:0] CRC_POLY = 16'hA001;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_end;
  } mbrc_in_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [15:0] data_word;
    logic [3:0]  valid_bits;
    logic [2:0]  frame_status;
    logic [7:0]  exception_code;
    logic        last;
  } mbrc_out_t;

  // One queue entry: the data item and the status item a byte may cause.
  typedef struct packed {
    logic        has_data;
    logic [1:0]  data_kind;
    logic [15:0] data_word;
    logic [3:0]  valid_bits;
    logic        has_status;
    logic [2:0]  frame_status;
    logic [7:0]  exception_code;
  } mbrc_cmd_t;

  function automatic logic [15:0] crc16_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int i = 0; i < 8; i++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: sv/modbus_rtu_response_checker_top.sv
// Modbus RTU response checker top: one received byte a cycle unless the queue is full;
// the results of a byte pass through the queue and then the output register.
// A byte that yields both a data and a status item puts a data beat and then a status beat
// on the output, and the four-entry queue absorbs the difference.
// Reset (rst_n low, synchronous) clears frame state, configuration, queue and output.
// Depends on mbrc_pkg, mbrc_front, mbrc_queue and mbrc_back.
module modbus_rtu_response_checker_top import mbrc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  mbrc_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output mbrc_out_t             out_data
);

  logic      q_push;
  mbrc_cmd_t q_cmd;
  logic      q_full;
  logic      q_pop;
  logic      q_head_valid;
  mbrc_cmd_t q_head_cmd;

  mbrc_front #(
    .MAX_FRAME_BYTES(MAX_FRAME_BYTES)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_valid (in_valid),
    .in_data  (in_data),
    .q_full   (q_full),
    .in_stall (in_stall),
    .q_push   (q_push),
    .q_cmd    (q_cmd)
  );

  mbrc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_cmd  (q_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .head_valid(q_head_valid),
    .head_cmd  (q_head_cmd)
  );

  mbrc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_valid(q_head_valid),
    .head_cmd  (q_head_cmd),
    .pop       (q_pop),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

// File: sv/mbrc_front.sv
// Modbus RTU response checker front: takes bytes, runs CRC and frame parse,
// and queues the resulting data and status items. Depends on mbrc_pkg.
module mbrc_front import mbrc_pkg::*; #(
  parameter int MAX_FRAME_BYTES = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata,
  input  logic                  in_valid,
  input  mbrc_in_t              in_data,
  input  logic                  q_full,
  output logic                  in_stall,
  output logic                  q_push,
  output mbrc_cmd_t             q_cmd
);

  localparam int LEN_W = $clog2(MAX_FRAME_BYTES + 1);
  localparam int CMP_W = ((LEN_W > 9) ? LEN_W : 9) + 1;
  localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_FRAME_BYTES);

  logic [1:0]       kind_r;
  logic [10:0]      exp_bits_r;
  logic [LEN_W-1:0] len_r, len_nxt;
  logic [15:0]      crc_r, crc_nxt;
  logic [7:0]       func_r, func_nxt;
  logic [7:0]       count_r, count_nxt;
  logic [7:0]       held_r, held_nxt;
  logic [10:0]      bits_r, bits_nxt;
  logic [15:0]      delay_r, delay_nxt;

  logic             accept;
  logic [CMP_W-1:0] off;
  logic [CMP_W-1:0] need_len;
  logic [CMP_W-1:0] len_ext;
  logic [3:0]       take;
  logic [7:0]       mask;
  logic [15:0]      rx_crc;
  mbrc_cmd_t        cmd;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  always_comb begin
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    func_nxt  = func_r;
    count_nxt = count_r;
    held_nxt  = held_r;
    bits_nxt  = bits_r;
    delay_nxt = {delay_r[7:0], in_data.rx_byte};
    cmd       = '0;
    off       = CMP_W'(len_r) - CMP_W'(3);
    take      = (bits_r < 11'd8) ? bits_r[3:0] : 4'd8;
    mask      = 8'((9'd1 << take) - 9'd1);

    if (len_r >= LEN_W'(2)) begin
      crc_nxt = crc16_byte(crc_r, delay_r[15:8]);
    end

    if (len_r < LEN_MAX) begin
      len_nxt = len_r + LEN_W'(1);
      if (len_r == LEN_W'(1)) begin
        func_nxt = in_data.rx_byte;
      end else if (len_r == LEN_W'(2)) begin
        count_nxt = in_data.rx_byte;
        bits_nxt  = exp_bits_r;
      end else if (len_r >= LEN_W'(3) && !func_r[7] && off < CMP_W'(count_r)) begin
        if (kind_r == KIND_REG_READ) begin
          if (!off[0]) begin
            held_nxt = in_data.rx_byte;
          end else begin
            cmd.has_data  = 1'b1;
            cmd.data_kind = ITEM_REG_WORD;
            cmd.data_word = {held_r, in_data.rx_byte};
          end
        end else if (kind_r == KIND_BIT_READ && bits_r != 11'd0) begin
          cmd.has_data   = 1'b1;
          cmd.data_kind  = ITEM_BIT_GROUP;
          cmd.data_word  = {8'h00, in_data.rx_byte & mask};
          cmd.valid_bits = take;
          bits_nxt       = bits_r - 11'(take);
        end
      end
    end

    len_ext  = CMP_W'(len_nxt);
    need_len = CMP_W'(count_nxt) + CMP_W'(5);
    rx_crc   = {delay_nxt[7:0], delay_nxt[15:8]};

    if (in_data.frame_end) begin
      cmd.has_status = 1'b1;
      if (len_nxt < LEN_W'(4)) begin
        cmd.frame_status = ST_SHORT;
      end else if (rx_crc != crc_nxt) begin
        cmd.frame_status = ST_CRC;
      end else if (func_nxt[7]) begin
        cmd.frame_status   = ST_EXCEPTION;
        cmd.exception_code = count_nxt;
      end else if (kind_r == KIND_BIT_READ || kind_r == KIND_REG_READ) begin
        if (len_nxt < LEN_W'(6)) begin
          cmd.frame_status = ST_DATA_SHORT;
        end else if (len_ext < need_len) begin
          cmd.frame_status = ST_INCOMPLETE;
        end else begin
          cmd.frame_status = ST_OK;
        end
      end else begin
        cmd.frame_status = (len_nxt < LEN_W'(8)) ? ST_WRITE_SHORT : ST_OK;
      end
    end
  end

  assign q_push = accept && (cmd.has_data || cmd.has_status);
  assign q_cmd  = cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kind_r     <= KIND_BIT_READ;
      exp_bits_r <= '0;
    end else if (cfg_we) begin
      if (cfg_index == REG_RESPONSE_KIND) begin
        kind_r <= cfg_wdata[1:0];
      end else if (cfg_index == REG_EXPECTED_BITS) begin
        exp_bits_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (accept && in_data.frame_end)) begin
      len_r   <= '0;
      crc_r   <= CRC_SEED;
      func_r  <= '0;
      count_r <= '0;
      held_r  <= '0;
      bits_r  <= '0;
      delay_r <= '0;
    end else if (accept) begin
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      func_r  <= func_nxt;
      count_r <= count_nxt;
      held_r  <= held_nxt;
      bits_r  <= bits_nxt;
      delay_r <= delay_nxt;
    end
  end

endmodule

// File: sv/mbrc_queue.sv
// Modbus RTU response checker queue: four-entry FIFO of item commands
// between front and back. Depends on mbrc_pkg.
module mbrc_queue import mbrc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  mbrc_cmd_t push_cmd,
  input  logic      pop,
  output logic      full,
  output logic      head_valid,
  output mbrc_cmd_t head_cmd
);

  localparam int DEPTH = 4;
  localparam int PTR_W = $clog2(DEPTH);

  mbrc_cmd_t        slot_r [DEPTH];
  logic [PTR_W-1:0] wr_r, wr_nxt;
  logic [PTR_W-1:0] rd_r, rd_nxt;
  logic [PTR_W:0]   cnt_r, cnt_nxt;

  assign full       = (cnt_r == (PTR_W+1)'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_cmd   = slot_r[rd_r];

  always_comb begin
    wr_nxt  = push ? wr_r + PTR_W'(1) : wr_r;
    rd_nxt  = pop ? rd_r + PTR_W'(1) : rd_r;
    cnt_nxt = cnt_r + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_r] <= push_cmd;
    end
  end

endmodule

// File: sv/mbrc_back.sv
// Modbus RTU response checker back: splits queued commands into output beats
// through an output register and a held status beat. Depends on mbrc_pkg.
module mbrc_back import mbrc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      head_valid,
  input  mbrc_cmd_t head_cmd,
  output logic      pop,
  input  logic      out_stall,
  output logic      out_valid,
  output mbrc_out_t out_data
);

  logic      out_valid_r, out_valid_nxt;
  mbrc_out_t out_r, out_nxt;
  logic      pend_r, pend_nxt;
  mbrc_out_t pend_item_r, pend_item_nxt;
  logic      slot_free;
  mbrc_out_t data_item;
  mbrc_out_t status_item;

  assign slot_free = !out_valid_r || !out_stall;
  assign pop       = slot_free && !pend_r && head_valid;

  always_comb begin
    data_item            = '0;
    data_item.item_kind  = head_cmd.data_kind;
    data_item.data_word  = head_cmd.data_word;
    data_item.valid_bits = head_cmd.valid_bits;

    status_item                = '0;
    status_item.item_kind      = ITEM_STATUS;
    status_item.frame_status   = head_cmd.frame_status;
    status_item.exception_code = head_cmd.exception_code;
    status_item.last           = 1'b1;

    out_valid_nxt = out_valid_r && out_stall;
    out_nxt       = out_r;
    pend_nxt      = pend_r;
    pend_item_nxt = pend_item_r;

    if (slot_free) begin
      if (pend_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_item_r;
        pend_nxt      = 1'b0;
      end else if (head_valid) begin
        out_valid_nxt = 1'b1;
        if (head_cmd.has_data) begin
          out_nxt       = data_item;
          pend_nxt      = head_cmd.has_status;
          pend_item_nxt = status_item;
        end else begin
          out_nxt = status_item;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      pend_r      <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      pend_r      <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r       <= out_nxt;
    pend_item_r <= pend_item_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: sv/mbrc_checker.sv
// Modbus RTU response checker port assertions and their bind to the top level.
// Depends on mbrc_pkg and modbus_rtu_response_checker_top.
module mbrc_checker import mbrc_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input mbrc_in_t              in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input mbrc_out_t             out_data
);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled input beat changed");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled output beat changed");

  a_last_on_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.item_kind == ITEM_STATUS) == out_data.last))
    else $error("last does not match status beat");

  a_data_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind != ITEM_STATUS |->
      out_data.frame_status == ST_OK && out_data.exception_code == 8'h00)
    else $error("data beat carries status fields");

  a_bit_group: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.item_kind == ITEM_BIT_GROUP |->
      out_data.valid_bits != 4'd0 && out_data.valid_bits <= 4'd8 &&
      out_data.data_word[15:8] == 8'h00)
    else $error("bit group beat malformed");

endmodule

bind modbus_rtu_response_checker_top mbrc_checker u_mbrc_checker (.*);

// File: sim/modbus_rtu_response_checker_top_test.sv
// Self-checking testbench for the Modbus RTU response checker top level.
// Drives framed response bytes against a cycle-free model of the checker and
// compares every result beat in order; depends on mbrc_pkg and the top level.
`timescale 1ns / 100ps

module modbus_rtu_response_checker_top_test;
  import mbrc_pkg::*;

  localparam int FRAME_CAP    = 256;
  localparam int RANDOM_ITEMS = 1700;
  localparam int SETTLE       = 8;

  localparam logic [1:0] KIND_WRITE_ACK = 2'd2;

  localparam logic [7:0] FN_READ_COILS        = 8'h01;
  localparam logic [7:0] FN_READ_INPUT_REGS   = 8'h04;
  localparam logic [7:0] FN_WRITE_SINGLE_COIL = 8'h05;
  localparam logic [7:0] FN_WRITE_MULTI_REGS  = 8'h10;
  localparam logic [7:0] EXCEPTION_FLAG       = 8'h80;

  typedef enum logic [2:0] {
    OP_BYTE, OP_CRC_LO, OP_CRC_HI, OP_SET_KIND, OP_SET_BITS
  } plan_op_e;

  typedef struct packed {
    plan_op_e    op;
    logic [10:0] val;
    logic        fe;
    logic        chk;
    logic [2:0]  st;
    logic [7:0]  code;
  } plan_row_t;

  localparam int PLAN_ROWS = 30;
  localparam plan_row_t PLAN [0:PLAN_ROWS-1] = '{
    '{OP_BYTE,     11'h0FF, 1'b1, 1'b1, ST_SHORT,       8'h00},
    '{OP_BYTE,     11'h011, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h081, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h002, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_CRC_LO,   11'h000, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_CRC_HI,   11'h000, 1'b1, 1'b1, ST_EXCEPTION,   8'h02},
    '{OP_SET_KIND, 11'd1,   1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h001, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h003, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h003, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h0AB, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h0CD, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h0EF, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_CRC_LO,   11'h000, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_CRC_HI,   11'h000, 1'b1, 1'b1, ST_OK,          8'h00},
    '{OP_SET_KIND, 11'd0,   1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_SET_BITS, 11'd3,   1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h001, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h001, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h001, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h0FF, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_CRC_LO,   11'h000, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_CRC_HI,   11'h000, 1'b1, 1'b1, ST_OK,          8'h00},
    '{OP_SET_KIND, 11'd2,   1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h001, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h006, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h000, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_BYTE,     11'h000, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_CRC_LO,   11'h000, 1'b0, 1'b0, ST_OK,          8'h00},
    '{OP_CRC_HI,   11'h000, 1'b1, 1'b1, ST_WRITE_SHORT, 8'h00}
  };

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  mbrc_in_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  mbrc_out_t             out_data;

  modbus_rtu_response_checker_top #(.MAX_FRAME_BYTES(FRAME_CAP)) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // shadow configuration and frame state
  logic [1:0]  want_kind = KIND_BIT_READ;
  logic [10:0] want_bits = '0;
  logic [8:0]  rx_len;
  logic [15:0] crc_acc;
  logic [7:0]  fn_code;
  logic [7:0]  byte_count;
  logic [7:0]  word_hi;
  logic [10:0] bits_left;
  logic [15:0] crc_tail;

  mbrc_out_t  pending_items [$];
  logic [7:0] frame_bytes [$];
  int         err_count  = 0;
  int         beat_no    = 0;
  int         items_sent = 0;
  bit         quiet_send = 1'b0;
  bit         quiet_recv = 1'b0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("CHECK FAILED");
    $finish;
  end

  function automatic logic [15:0] crc16_next(input logic [15:0] acc, input logic [7:0] b);
    logic [15:0] c;
    logic        fb;
    c = acc;
    for (int i = 0; i < 8; i++) begin
      fb = c[0] ^ b[i];
      c  = c >> 1;
      if (fb) c = c ^ CRC_POLY;
    end
    return c;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("mismatch at beat %0d, %s: got %0h, want %0h", beat_no, what, got, want);
    err_count++;
  endtask

  task automatic clear_frame_state();
    rx_len     = '0;
    crc_acc    = CRC_SEED;
    fn_code    = '0;
    byte_count = '0;
    word_hi    = '0;
    bits_left  = '0;
    crc_tail   = '0;
  endtask

  task automatic predict_byte(input mbrc_in_t d);
    logic [8:0]  pos;
    logic [8:0]  off;
    logic [8:0]  len;
    logic [3:0]  take;
    logic [8:0]  mask;
    logic [15:0] got_crc;
    mbrc_out_t   r;
    pos = rx_len;
    if (pos >= 2) crc_acc = crc16_next(crc_acc, crc_tail[15:8]);
    crc_tail = {crc_tail[7:0], d.rx_byte};
    if (pos < FRAME_CAP) begin
      if (pos == 1) begin
        fn_code = d.rx_byte;
      end else if (pos == 2) begin
        byte_count = d.rx_byte;
        bits_left  = want_bits;
      end else if (pos >= 3 && !fn_code[7]) begin
        off = pos - 9'd3;
        r   = '0;
        if (off < {1'b0, byte_count}) begin
          if (want_kind == KIND_REG_READ) begin
            if (!off[0]) begin
              word_hi = d.rx_byte;
            end else begin
              r.item_kind = ITEM_REG_WORD;
              r.data_word = {word_hi, d.rx_byte};
              pending_items.push_back(r);
            end
          end else if (want_kind == KIND_BIT_READ && bits_left != 0) begin
            take = (bits_left < 11'd8) ? bits_left[3:0] : 4'd8;
            mask = (9'd1 << take) - 9'd1;
            r.item_kind  = ITEM_BIT_GROUP;
            r.data_word  = {8'h00, d.rx_byte & mask[7:0]};
            r.valid_bits = take;
            pending_items.push_back(r);
            bits_left = bits_left - 11'(take);
          end
        end
      end
      rx_len = pos + 9'd1;
    end
    if (d.frame_end) begin
      len     = rx_len;
      got_crc = {crc_tail[7:0], crc_tail[15:8]};
      r       = '0;
      r.item_kind = ITEM_STATUS;
      r.last      = 1'b1;
      if (len < 4) begin
        r.frame_status = ST_SHORT;
      end else if (got_crc != crc_acc) begin
        r.frame_status = ST_CRC;
      end else if (fn_code[7]) begin
        r.frame_status   = ST_EXCEPTION;
        r.exception_code = byte_count;
      end else if (!want_kind[1]) begin
        if (len < 6)
          r.frame_status = ST_DATA_SHORT;
        else if (int'(len) < 5 + int'(byte_count))
          r.frame_status = ST_INCOMPLETE;
        else
          r.frame_status = ST_OK;
      end else begin
        r.frame_status = (len < 8) ? ST_WRITE_SHORT : ST_OK;
      end
      pending_items.push_back(r);
      clear_frame_state();
    end
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fe);
    int       gap;
    mbrc_in_t d;
    gap = quiet_send ? 0 : $urandom_range(0, 18);
    d.rx_byte   = b;
    d.frame_end = fe;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= d;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_byte(d);
    items_sent++;
  endtask

  task automatic idle_until_drained(input int extra);
    in_valid <= 1'b0;
    while (pending_items.size() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_RESPONSE_KIND)
      want_kind = val[1:0];
    else
      want_bits = val;
    @(posedge clk);
  endtask

  task automatic make_frame();
    int          shape;
    int          count;
    int          extra;
    int          pos;
    logic [7:0]  fn;
    logic [15:0] c;
    frame_bytes.delete();
    shape = $urandom_range(0, 99);
    if (shape < 8) begin
      repeat ($urandom_range(1, 12)) frame_bytes.push_back(8'($urandom));
      return;
    end
    frame_bytes.push_back(8'($urandom));
    if (want_kind >= KIND_WRITE_ACK && shape < 85) begin
      frame_bytes.push_back($urandom_range(0, 1) ? FN_WRITE_SINGLE_COIL : FN_WRITE_MULTI_REGS);
      repeat (4) frame_bytes.push_back(8'($urandom));
    end else begin
      fn = 8'($urandom_range(FN_READ_COILS, FN_READ_INPUT_REGS));
      if ($urandom_range(0, 9) == 0) fn = fn | EXCEPTION_FLAG;
      extra = (shape >= 28 && shape < 36) ? $urandom_range(1, 3) : 0;
      if ($urandom_range(0, 39) == 0) begin
        count = $urandom_range(250, 255);
        extra = $urandom_range(0, 6);
      end else begin
        count = $urandom_range(0, 12);
      end
      frame_bytes.push_back(fn);
      frame_bytes.push_back(8'(count));
      if (!fn[7]) repeat (count + extra) frame_bytes.push_back(8'($urandom));
    end
    // truncate before the checksum
    if (shape < 16) repeat ($urandom_range(1, frame_bytes.size() - 1)) frame_bytes.pop_back();
    c = CRC_SEED;
    foreach (frame_bytes[i]) c = crc16_next(c, frame_bytes[i]);
    frame_bytes.push_back(c[7:0]);
    frame_bytes.push_back(c[15:8]);
    if (shape >= 16 && shape < 24) begin
      pos = $urandom_range(0, frame_bytes.size() - 1);
      frame_bytes[pos] = frame_bytes[pos] ^ 8'(1 << $urandom_range(0, 7));
    end else if (shape >= 24 && shape < 28) begin
      frame_bytes.push_back(8'($urandom));
    end
  endtask

  initial begin
    int hold;
    @(posedge clk);
    forever begin
      if ($urandom_range(0, 19) == 0) quiet_recv = !quiet_recv;
      hold = quiet_recv ? 0 : $urandom_range(0, 18);
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    mbrc_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_items.size() == 0) begin
        report_mismatch("beat with nothing pending", out_data.data_word, '0);
      end else begin
        want = pending_items.pop_front();
        if (out_data.item_kind != want.item_kind)
          report_mismatch("item_kind", 16'(out_data.item_kind), 16'(want.item_kind));
        if (out_data.data_word != want.data_word)
          report_mismatch("data_word", out_data.data_word, want.data_word);
        if (out_data.valid_bits != want.valid_bits)
          report_mismatch("valid_bits", 16'(out_data.valid_bits), 16'(want.valid_bits));
        if (out_data.frame_status != want.frame_status)
          report_mismatch("frame_status", 16'(out_data.frame_status),
                          16'(want.frame_status));
        if (out_data.exception_code != want.exception_code)
          report_mismatch("exception_code", 16'(out_data.exception_code),
                          16'(want.exception_code));
        if (out_data.last != want.last)
          report_mismatch("last", 16'(out_data.last), 16'(want.last));
      end
      beat_no++;
    end
  end

  initial begin
    logic [15:0] frame_crc;
    mbrc_out_t   newest;
    int          pidx;
    int          target;
    logic [10:0] bits_val;
    clear_frame_state();
    frame_crc = CRC_SEED;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    for (int i = 0; i < PLAN_ROWS; i++) begin
      case (PLAN[i].op)
        OP_SET_KIND: begin
          idle_until_drained(SETTLE);
          write_reg(REG_RESPONSE_KIND, PLAN[i].val);
        end
        OP_SET_BITS: begin
          idle_until_drained(SETTLE);
          write_reg(REG_EXPECTED_BITS, PLAN[i].val);
        end
        OP_CRC_LO: send_byte(frame_crc[7:0], PLAN[i].fe);
        OP_CRC_HI: send_byte(frame_crc[15:8], PLAN[i].fe);
        default: begin
          send_byte(PLAN[i].val[7:0], PLAN[i].fe);
          frame_crc = crc16_next(frame_crc, PLAN[i].val[7:0]);
        end
      endcase
      if (PLAN[i].fe) frame_crc = CRC_SEED;
      if (PLAN[i].chk) begin
        newest = (pending_items.size() != 0) ? pending_items[$] : '0;
        if (newest.frame_status != PLAN[i].st)
          report_mismatch("directed status", 16'(newest.frame_status), 16'(PLAN[i].st));
        if (newest.exception_code != PLAN[i].code)
          report_mismatch("directed exception code", 16'(newest.exception_code),
                          16'(PLAN[i].code));
      end
    end

    pidx   = 0;
    target = items_sent + RANDOM_ITEMS;
    while (items_sent < target) begin
      idle_until_drained(SETTLE);
      case (pidx / 4)
        0:       bits_val = 11'd2000;
        1:       bits_val = 11'd0;
        2:       bits_val = 11'($urandom_range(1, 9));
        default: bits_val = 11'($urandom_range(0, 2000));
      endcase
      write_reg(REG_RESPONSE_KIND, CFG_DATA_W'(pidx % 4));
      write_reg(REG_EXPECTED_BITS, bits_val);
      repeat ($urandom_range(4, 10)) begin
        if ($urandom_range(0, 3) == 0) quiet_send = !quiet_send;
        make_frame();
        foreach (frame_bytes[i]) send_byte(frame_bytes[i], i == frame_bytes.size() - 1);
        // now and then, hold the sender until every result is out
        if ($urandom_range(0, 14) == 0) idle_until_drained(1);
      end
      pidx++;
    end

    idle_until_drained(SETTLE);
    if (err_count == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule
